/* hw/rtl/mini_block_bitunpack_decoder_macros.svh */
// assertion macros shared by the bit-unpacking decoder rtl
`ifndef MINI_BLOCK_BITUNPACK_DECODER_MACROS_SVH
`define MINI_BLOCK_BITUNPACK_DECODER_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define MBU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mbu assertion failed");

// next-cycle implication, checked on every clock edge outside reset
`define MBU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mbu assertion failed");

`endif

/* hw/rtl/mbu_pkg.sv */
// types and constants of the bit-unpacking decoder
package mbu_pkg;

	localparam int unsigned WordBits = 32;
	localparam int unsigned CntW     = 7;
	localparam int unsigned WidthW   = 6;
	localparam int unsigned AvailW   = 4;

	// header codes: full block up to 32, short block up to 65, padding above
	localparam logic [7:0] HdrFullMax  = 8'd32;
	localparam logic [7:0] HdrShortMax = 8'd65;
	localparam logic [7:0] HdrShortBase = 8'd33;

	// decoder phase, one-hot
	typedef enum logic [4:0] {
		PH_HEADER  = 5'b00001,
		PH_COUNT   = 5'b00010,
		PH_SKIP    = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_ZEROS   = 5'b10000
	} phase_t;

endpackage

/* hw/rtl/mini_block_bitunpack_decoder.sv */
// top level of the mini-block bit-unpacking decoder
// Usage:
//  s_axis carries the packed stream, one byte per beat in tdata; tlast marks the
//  end of the stream, after which the decoder expects a header again and drops
//  any partly assembled value.
//  m_axis carries one unpacked value per beat: tdata is the 32-bit value, tlast
//  marks the last value of a block, tuser marks the last value caused by one
//  input byte.
//  An accepted byte lands in an item register; a single step unit works on it,
//  one step a cycle unless a value waits on a stalled m_axis, and a payload
//  value passes the item and output registers in turn; zero values follow the
//  step of their header or count byte. Throughput: one byte per cycle while
//  m_axis does not stall, when a byte yields at most one value and leaves no
//  bits for a following value; a payload byte takes one step per value it
//  completes plus one for its trailing partial bits; a zero-width block takes
//  one step for its header or count plus one per zero value.
//  Reset clears phase, block state and the valid flags of both registers; the
//  decoder then expects a header byte.
//  When m_axis stalls, the step unit holds its item and s_axis tready drops once
//  the item register cannot be freed; nothing is lost or repeated.
module mini_block_bitunpack_decoder
	import mbu_pkg::*;
#(
	parameter int unsigned BLOCK_SIZE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,   // end_of_stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] value
	output logic        m_axis_tlast,   // block_end
	output logic        m_axis_tuser    // [0] item_last
);

	localparam logic [7:0]      BlkSizeB = 8'(BLOCK_SIZE);
	localparam logic [CntW-1:0] BlkSizeC = CntW'(BLOCK_SIZE);

	// block state
	phase_t              phase_q, phase_n;
	logic [WidthW-1:0]   width_q, width_n;
	logic [CntW-1:0]     left_q, left_n;
	logic [WordBits-1:0] partial_q, partial_n;
	logic [WidthW-1:0]   filled_q, filled_n;

	// item register
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              eos_s1;
	logic [AvailW-1:0] avail_s1, avail_n;

	// output register
	logic                out_valid_q;
	logic [WordBits-1:0] out_value_q;
	logic                out_bend_q;
	logic                out_last_q;

	// step results
	logic                step_emit, step_end;
	logic [WordBits-1:0] res_value;
	logic                res_bend, res_last;
	logic                out_free, fire, accept;

	// payload step datapath
	logic [WidthW-1:0]   need;
	logic [AvailW-1:0]   take, shamt;
	logic [7:0]          chunk;
	logic [WordBits-1:0] merged;
	logic [WidthW-1:0]   filled_sum;
	logic [CntW-1:0]     cnt_sat;

	always_comb begin
		need       = width_q - filled_q;
		take       = (need < WidthW'(avail_s1)) ? AvailW'(need) : avail_s1;
		shamt      = avail_s1 - take;
		chunk      = (byte_s1 >> shamt) & 8'((9'd1 << take) - 9'd1);
		merged     = partial_q | (WordBits'(chunk) << filled_q);
		filled_sum = filled_q + WidthW'(take);
		cnt_sat    = (byte_s1 > BlkSizeB) ? BlkSizeC : byte_s1[CntW-1:0];
	end

	// one step of the decoder on the held byte
	always_comb begin
		phase_n   = phase_q;
		width_n   = width_q;
		left_n    = left_q;
		partial_n = partial_q;
		filled_n  = filled_q;
		avail_n   = avail_s1;
		step_emit = 1'b0;
		step_end  = 1'b1;
		res_value = '0;
		res_bend  = 1'b0;
		res_last  = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				if (byte_s1 <= HdrFullMax) begin
					width_n   = byte_s1[WidthW-1:0];
					left_n    = BlkSizeC;
					partial_n = '0;
					filled_n  = '0;
					if (byte_s1 == 8'd0) begin
						phase_n  = PH_ZEROS;
						step_end = 1'b0;
					end else begin
						phase_n = PH_PAYLOAD;
					end
				end else if (byte_s1 <= HdrShortMax) begin
					width_n = WidthW'(byte_s1 - HdrShortBase);
					phase_n = PH_COUNT;
				end else begin
					phase_n = PH_SKIP;
				end
			end
			PH_COUNT: begin
				partial_n = '0;
				filled_n  = '0;
				left_n    = cnt_sat;
				if (cnt_sat == '0) begin
					phase_n = PH_HEADER;
				end else if (width_q == '0) begin
					phase_n  = PH_ZEROS;
					step_end = 1'b0;
				end else begin
					phase_n = PH_PAYLOAD;
				end
			end
			PH_SKIP: begin
				phase_n = PH_HEADER;
			end
			PH_ZEROS: begin
				step_emit = 1'b1;
				left_n    = left_q - CntW'(1);
				res_bend  = (left_n == '0);
				res_last  = res_bend;
				step_end  = res_bend;
				if (res_bend) begin
					phase_n = PH_HEADER;
				end
			end
			PH_PAYLOAD: begin
				if (width_q == '0 || width_q > WidthW'(WordBits)) begin
					phase_n   = PH_HEADER;
					left_n    = '0;
					partial_n = '0;
					filled_n  = '0;
				end else begin
					avail_n = avail_s1 - take;
					if (filled_sum == width_q) begin
						step_emit = 1'b1;
						res_value = merged;
						left_n    = left_q - CntW'(1);
						partial_n = '0;
						filled_n  = '0;
						res_bend  = (left_n == '0);
						step_end  = (avail_n == '0) || (left_n == '0);
						res_last  = step_end || (WidthW'(avail_n) < width_q);
					end else begin
						partial_n = merged;
						filled_n  = filled_sum;
						step_end  = 1'b1;
					end
					if (left_n == '0) begin
						phase_n   = PH_HEADER;
						partial_n = '0;
						filled_n  = '0;
					end
				end
			end
			default: begin
				phase_n   = PH_HEADER;
				left_n    = '0;
				partial_n = '0;
				filled_n  = '0;
			end
		endcase
		// end of stream clears the block after the byte is done
		if (step_end && eos_s1) begin
			phase_n   = PH_HEADER;
			left_n    = '0;
			partial_n = '0;
			filled_n  = '0;
		end
	end

	// handshake
	assign out_free      = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && (!step_emit || out_free);
	assign s_axis_tready = !valid_s1 || (fire && step_end);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// block state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			width_q   <= '0;
			left_q    <= '0;
			partial_q <= '0;
			filled_q  <= '0;
		end else if (fire) begin
			phase_q   <= phase_n;
			width_q   <= width_n;
			left_q    <= left_n;
			partial_q <= partial_n;
			filled_q  <= filled_n;
		end
	end

	// item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			avail_s1 <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			avail_s1 <= AvailW'(8);
		end else if (fire && step_end) begin
			valid_s1 <= 1'b0;
		end else if (fire) begin
			avail_s1 <= avail_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= s_axis_tdata;
			eos_s1  <= s_axis_tlast;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire && step_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && step_emit) begin
			out_value_q <= res_value;
			out_bend_q  <= res_bend;
			out_last_q  <= res_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_value_q;
	assign m_axis_tlast  = out_bend_q;
	assign m_axis_tuser  = out_last_q;

`include "mini_block_bitunpack_decoder_macros.svh"

	// a zero run always has values left to send
	`MBU_ASSERT_IMP(a_zeros_left, phase_q == PH_ZEROS, left_q != '0)
	// payload only runs with a width of 1..32
	`MBU_ASSERT_IMP(a_payload_width, phase_q == PH_PAYLOAD, width_q != '0 && width_q <= WidthW'(WordBits))
	// the value under assembly is never full
	`MBU_ASSERT_IMP(a_filled_below, phase_q == PH_PAYLOAD, filled_q < width_q)
	// remaining count never exceeds the block size
	`MBU_ASSERT_IMP(a_left_bound, 1'b1, left_q <= BlkSizeC)
	// a held beat stays while the receiver stalls and a step waits on it
	`MBU_ASSERT_NXT(a_emit_waits, valid_s1 && step_emit && !out_free, valid_s1 && out_valid_q)

endmodule

/* bench/tb_mini_block_bitunpack_decoder.sv */
// testbench of the mini-block bit-unpacking decoder: directed and random byte streams
`timescale 1ns / 100ps

module tb_mini_block_bitunpack_decoder
	import mbu_pkg::*;
();

	localparam int BLOCK_SIZE  = 64;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_LIMIT = 20_000;

	// one unpacked value as it leaves the decoder
	typedef struct {
		logic [31:0] value;
		logic        block_end;
		logic        item_last;
	} unpacked_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;   // [7:0] in_byte
	logic        s_axis_tlast  = 1'b0; // end_of_stream
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;         // [31:0] value
	logic        m_axis_tlast;         // block_end
	logic        m_axis_tuser;         // [0] item_last

	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	int bytes_sent    = 0;
	int error_count   = 0;
	int cycle_count   = 0;

	// decoder state as the predictor sees it
	phase_t      dec_phase   = PH_HEADER;
	logic [5:0]  dec_width   = '0;
	logic [6:0]  dec_left    = '0;
	logic [31:0] dec_partial = '0;
	logic [5:0]  dec_filled  = '0;

	unpacked_t values_due[$];
	unpacked_t head;

	mini_block_bitunpack_decoder #(
		.BLOCK_SIZE(BLOCK_SIZE)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	always #4 clk = ~clk;

	// back to waiting for a header, partial value dropped
	function automatic void clear_block();
		dec_phase   = PH_HEADER;
		dec_left    = '0;
		dec_partial = '0;
		dec_filled  = '0;
	endfunction

	function automatic void due_value(input logic [31:0] v, input logic blk_end);
		values_due.push_back('{value: v, block_end: blk_end, item_last: 1'b0});
	endfunction

	// zero-width blocks emit everything at once, others wait for payload
	function automatic void open_block(input logic [5:0] w, input int count);
		dec_width   = w;
		dec_partial = '0;
		dec_filled  = '0;
		if (count == 0) begin
			clear_block();
		end else if (w == 0) begin
			for (int k = 0; k < count; k++)
				due_value('0, k + 1 == count);
			clear_block();
		end else begin
			dec_left  = 7'(count);
			dec_phase = PH_PAYLOAD;
		end
	endfunction

	// values that one accepted byte produces
	function automatic void unpack_byte(input logic [7:0] b, input logic eos);
		int        first_idx;
		int        avail;
		int        need;
		int        take;
		logic [31:0] chunk;
		unpacked_t last_val;
		first_idx = values_due.size();
		case (dec_phase)
			PH_HEADER: begin
				if (b <= HdrFullMax) begin
					open_block(b[5:0], BLOCK_SIZE);
				end else if (b <= HdrShortMax) begin
					dec_width = 6'(b - HdrShortBase);
					dec_phase = PH_COUNT;
				end else begin
					dec_phase = PH_SKIP;
				end
			end
			PH_COUNT: begin
				open_block(dec_width, (int'(b) > BLOCK_SIZE) ? BLOCK_SIZE : int'(b));
			end
			PH_SKIP: begin
				dec_phase = PH_HEADER;
			end
			default: begin
				// payload bits come from the top of the byte, fill values from bit 0
				avail = 8;
				while (avail > 0 && dec_left > 0) begin
					need  = int'(dec_width) - int'(dec_filled);
					take  = (need < avail) ? need : avail;
					chunk = (32'(b) >> (avail - take)) & ((32'd1 << take) - 32'd1);
					dec_partial = dec_partial | (chunk << dec_filled);
					dec_filled  = dec_filled + 6'(take);
					avail       = avail - take;
					if (dec_filled == dec_width) begin
						dec_left = dec_left - 7'd1;
						due_value(dec_partial, dec_left == 0);
						dec_partial = '0;
						dec_filled  = '0;
					end
				end
				if (dec_left == 0)
					clear_block();
			end
		endcase
		if (eos)
			clear_block();
		if (values_due.size() > first_idx) begin
			last_val = values_due.pop_back();
			last_val.item_last = 1'b1;
			values_due.push_back(last_val);
		end
	endfunction

	// one input beat, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input logic eos);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eos;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		unpack_byte(b, eos);
		bytes_sent++;
	endtask

	// hold the stream until every predicted value has come out
	task automatic wait_for_values();
		int waited;
		waited = 0;
		s_axis_tvalid <= 1'b0;
		while (values_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (values_due.size() != 0) begin
			$error("%0d expected values never arrived", values_due.size());
			error_count++;
			values_due.delete();
		end
	endtask

	task automatic test_zero_width();
		send_byte(8'd0, 1'b0);                    // full block, 64 zeros at once
		send_byte(HdrShortBase, 1'b0);            // short block of width 0
		send_byte(8'd5, 1'b0);
		send_byte(HdrShortBase, 1'b0);            // count above block size saturates
		send_byte(8'd200, 1'b0);
		send_byte(HdrShortBase + 8'd7, 1'b0);     // count zero emits nothing
		send_byte(8'd0, 1'b0);
	endtask

	task automatic test_short_blocks();
		// widest value spans four bytes
		send_byte(HdrShortMax, 1'b0);
		send_byte(8'd1, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'ha5, 1'b0);
		send_byte(8'h5a, 1'b0);
		// eight one-bit values from a single byte
		send_byte(HdrShortBase + 8'd1, 1'b0);
		send_byte(8'd8, 1'b0);
		send_byte(8'hb4, 1'b0);
		// three 3-bit values, trailing bits of the last byte dropped
		send_byte(HdrShortBase + 8'd3, 1'b0);
		send_byte(8'd3, 1'b0);
		send_byte(8'h5c, 1'b0);
		send_byte(8'hff, 1'b0);
	endtask

	task automatic test_padding();
		send_byte(8'd255, 1'b0);
		send_byte(8'hab, 1'b0);
	endtask

	task automatic test_end_of_stream();
		// partial value dropped mid payload
		send_byte(HdrShortBase + 8'd7, 1'b0);
		send_byte(8'd3, 1'b0);
		send_byte(8'hf0, 1'b1);
		send_byte(8'd5, 1'b1);                    // on a full block header
		send_byte(8'd66, 1'b0);                   // on the skipped byte
		send_byte(8'h12, 1'b1);
		send_byte(HdrShortBase + 8'd17, 1'b1);    // while a count is expected
	endtask

	// one random block, mostly well formed, sometimes cut by end of stream
	task automatic send_random_block();
		int         roll;
		int         w;
		int         cnt;
		int         nbytes;
		int         cut;
		logic [7:0] cnt_byte;
		roll = $urandom_range(0, 99);
		if (roll < 6) begin
			send_byte(8'($urandom_range(66, 255)), 1'b0);
			send_byte(8'($urandom), 1'b0);
		end else if (roll < 10) begin
			// stray byte that closes the stream
			send_byte(8'($urandom), 1'b1);
		end else if (roll < 24) begin
			// full block: narrow ones run to completion, wide ones get cut short
			w = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 32) : $urandom_range(0, 3);
			nbytes = (w <= 3) ? w * BLOCK_SIZE / 8 : $urandom_range(1, 12);
			send_byte(8'(w), 1'b0);
			for (int i = 0; i < nbytes; i++)
				send_byte(8'($urandom), w > 3 && i == nbytes - 1);
		end else begin
			// short block, large counts only at small widths
			roll = $urandom_range(0, 99);
			if (roll < 85) begin
				cnt_byte = 8'($urandom_range(0, 12));
				w = $urandom_range(0, 32);
			end else begin
				cnt_byte = (roll < 95) ? 8'($urandom_range(13, 64)) : 8'($urandom_range(65, 255));
				w = $urandom_range(0, 4);
			end
			cnt = (int'(cnt_byte) > BLOCK_SIZE) ? BLOCK_SIZE : int'(cnt_byte);
			nbytes = (w * cnt + 7) / 8;
			cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, nbytes + 1) : -1;
			send_byte(HdrShortBase + 8'(w), cut == 0);
			if (cut == 0)
				return;
			send_byte(cnt_byte, cut == 1);
			if (cut == 1)
				return;
			for (int i = 0; i < nbytes; i++) begin
				send_byte(8'($urandom), cut == i + 2);
				if (cut == i + 2)
					return;
			end
		end
	endtask

	task automatic test_random_stream(input int idle_pct, input int stall_pct, input int n_bytes);
		int   stop_at;
		logic paused;
		src_idle_pct  = idle_pct;
		snk_stall_pct = stall_pct;
		stop_at = bytes_sent + n_bytes;
		paused  = 1'b0;
		while (bytes_sent < stop_at) begin
			send_random_block();
			// halfway through, let the output run dry once
			if (!paused && bytes_sent >= stop_at - n_bytes / 2) begin
				wait_for_values();
				paused = 1'b1;
			end
		end
		wait_for_values();
	endtask

	// receiver stalls
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);

	// compare each output beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (values_due.size() == 0) begin
				$error("unexpected value %h", m_axis_tdata);
				error_count++;
			end else begin
				head = values_due.pop_front();
				if (m_axis_tdata !== head.value) begin
					$error("value: expected %h, actual %h", head.value, m_axis_tdata);
					error_count++;
				end
				if (m_axis_tlast !== head.block_end) begin
					$error("block_end: expected %b, actual %b", head.block_end, m_axis_tlast);
					error_count++;
				end
				if (m_axis_tuser !== head.item_last) begin
					$error("item_last: expected %b, actual %b", head.item_last, m_axis_tuser);
					error_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_width();
		test_short_blocks();
		test_padding();
		test_end_of_stream();
		wait_for_values();

		test_random_stream(0, 0, 85);
		test_random_stream(87, 0, 85);
		test_random_stream(0, 87, 85);
		test_random_stream(23, 23, 85);

		wait_for_values();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* mini_block_bitunpack_decoder.f */
+incdir+hw/rtl
hw/rtl/mbu_pkg.sv
hw/rtl/mini_block_bitunpack_decoder.sv
bench/tb_mini_block_bitunpack_decoder.sv
